@@ src/sorq_pkg.sv @@
package sorq_pkg;

  localparam int NUM_SLOTS = 16;

  localparam int DIST_W  = 13;
  localparam int SLOT_W  = 4;
  localparam int WGT_W   = 9;
  localparam int CONF_W  = 4;
  localparam int TOTAL_W = 5;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_THRESH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_THRESH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_CONF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REL_CONF   = 3'd6;

  // slot modes, candidate classes
  localparam logic [1:0] MODE_FREE     = 2'd0;
  localparam logic [1:0] MODE_OCCUPIED = 2'd1;
  localparam logic [1:0] MODE_ERROR    = 2'd2;
  localparam logic [1:0] CAND_AMBIG    = 2'd3;

  // events
  localparam logic [1:0] EVENT_NONE     = 2'd0;
  localparam logic [1:0] EVENT_OCCUPIED = 2'd1;
  localparam logic [1:0] EVENT_FREED    = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              sensor_ok;
    logic [DIST_W-1:0] raw_distance;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_echo;
    logic [1:0]         slot_event;
    logic [1:0]         slot_status;
    logic [DIST_W-1:0]  smoothed_distance;
    logic [TOTAL_W-1:0] occupied_total;
    logic [TOTAL_W-1:0] error_total;
    logic [TOTAL_W-1:0] available_total;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] min_valid_distance;
    logic [DIST_W-1:0] max_valid_distance;
    logic [DIST_W-1:0] occupied_threshold;
    logic [DIST_W-1:0] free_threshold;
    logic [WGT_W-1:0]  filter_weight;
    logic [CONF_W-1:0] occupy_confirmations;
    logic [CONF_W-1:0] release_confirmations;
  } cfg_t;

endpackage

@@ src/sorq_step.sv @@
module sorq_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  sorq_pkg::in_item_t  item,
  input  sorq_pkg::cfg_t      cfg,
  output sorq_pkg::out_item_t res
);

  logic [1:0]                  mode_r    [sorq_pkg::NUM_SLOTS];
  logic                        saved_r   [sorq_pkg::NUM_SLOTS];
  logic                        pend_r    [sorq_pkg::NUM_SLOTS];
  logic [sorq_pkg::CONF_W-1:0] tally_r   [sorq_pkg::NUM_SLOTS];
  logic [sorq_pkg::DIST_W-1:0] filt_r    [sorq_pkg::NUM_SLOTS];
  logic                        primed_r  [sorq_pkg::NUM_SLOTS];
  logic [sorq_pkg::TOTAL_W-1:0] occ_r, flt_r;

  logic [1:0]                  mode_nxt;
  logic                        saved_nxt;
  logic                        pend_nxt;
  logic [sorq_pkg::CONF_W-1:0] tally_nxt;
  logic [sorq_pkg::DIST_W-1:0] filt_nxt;
  logic                        primed_nxt;
  logic [sorq_pkg::TOTAL_W-1:0] occ_nxt, flt_nxt;

  logic [sorq_pkg::SLOT_W-1:0] s;
  logic [1:0]                  mode_cur;
  logic [sorq_pkg::DIST_W-1:0] filt_cur;
  logic                        reading_ok;
  logic [sorq_pkg::WGT_W-1:0]  w_eff;
  logic signed [13:0]          diff;
  logic signed [23:0]          prod;
  logic signed [23:0]          acc;
  logic [1:0]                  cand;
  logic [sorq_pkg::CONF_W-1:0] tally_inc;
  logic [sorq_pkg::CONF_W-1:0] need;
  logic [1:0]                  rec;
  logic [1:0]                  event_c;

  assign s        = item.slot_index;
  assign mode_cur = mode_r[s];
  assign filt_cur = filt_r[s];

  assign reading_ok = item.sensor_ok &&
                      (item.raw_distance >= cfg.min_valid_distance) &&
                      (item.raw_distance <= cfg.max_valid_distance);

  always_comb begin
    if (cfg.filter_weight == '0) begin
      w_eff = sorq_pkg::WGT_W'(1);
    end else if (cfg.filter_weight > sorq_pkg::WGT_W'(256)) begin
      w_eff = sorq_pkg::WGT_W'(256);
    end else begin
      w_eff = cfg.filter_weight;
    end
  end

  // old*256 + w*(raw-old) + 128, then >> 8
  assign diff = $signed({1'b0, item.raw_distance}) - $signed({1'b0, filt_cur});
  assign prod = 24'(diff * $signed({1'b0, w_eff}));
  assign acc  = $signed({3'b000, filt_cur, 8'h00}) + prod + 24'sd128;

  always_comb begin
    mode_nxt   = mode_cur;
    saved_nxt  = saved_r[s];
    pend_nxt   = pend_r[s];
    tally_nxt  = tally_r[s];
    filt_nxt   = filt_cur;
    primed_nxt = primed_r[s];
    event_c    = sorq_pkg::EVENT_NONE;
    cand       = sorq_pkg::CAND_AMBIG;
    tally_inc  = '0;
    need       = '0;
    rec        = sorq_pkg::MODE_FREE;

    if (!reading_ok) begin
      if (mode_cur != sorq_pkg::MODE_ERROR) begin
        saved_nxt = mode_cur[0];
        mode_nxt  = sorq_pkg::MODE_ERROR;
      end
    end else begin
      primed_nxt = 1'b1;
      if (!primed_r[s]) begin
        filt_nxt = item.raw_distance;
      end else begin
        filt_nxt = acc[20:8];
      end

      if (filt_nxt <= cfg.occupied_threshold) begin
        cand = sorq_pkg::MODE_OCCUPIED;
      end else if (filt_nxt >= cfg.free_threshold) begin
        cand = sorq_pkg::MODE_FREE;
      end

      if (mode_cur == sorq_pkg::MODE_ERROR) begin
        rec       = (cand == sorq_pkg::CAND_AMBIG) ? {1'b0, saved_r[s]} : cand;
        mode_nxt  = rec;
        pend_nxt  = 1'b0;
        tally_nxt = '0;
        if (rec != {1'b0, saved_r[s]}) begin
          event_c = (rec == sorq_pkg::MODE_OCCUPIED) ? sorq_pkg::EVENT_OCCUPIED
                                                     : sorq_pkg::EVENT_FREED;
        end
      end else if (cand == sorq_pkg::CAND_AMBIG || cand == mode_cur) begin
        pend_nxt  = 1'b0;
        tally_nxt = '0;
      end else begin
        if (cand[0] == pend_r[s]) begin
          tally_inc = (tally_r[s] == '1) ? tally_r[s] : tally_r[s] + 1'b1;
        end else begin
          tally_inc = sorq_pkg::CONF_W'(1);
        end
        need = (cand == sorq_pkg::MODE_OCCUPIED) ? cfg.occupy_confirmations
                                                 : cfg.release_confirmations;
        if (need == '0) begin
          need = sorq_pkg::CONF_W'(1);
        end
        if (tally_inc < need) begin
          pend_nxt  = cand[0];
          tally_nxt = tally_inc;
        end else begin
          mode_nxt  = cand;
          pend_nxt  = 1'b0;
          tally_nxt = '0;
          event_c   = (cand == sorq_pkg::MODE_OCCUPIED) ? sorq_pkg::EVENT_OCCUPIED
                                                        : sorq_pkg::EVENT_FREED;
        end
      end
    end
  end

  assign occ_nxt = occ_r
                 + {4'b0000, mode_nxt == sorq_pkg::MODE_OCCUPIED}
                 - {4'b0000, mode_cur == sorq_pkg::MODE_OCCUPIED};
  assign flt_nxt = flt_r
                 + {4'b0000, mode_nxt == sorq_pkg::MODE_ERROR}
                 - {4'b0000, mode_cur == sorq_pkg::MODE_ERROR};

  always_comb begin
    res.slot_echo         = s;
    res.slot_event        = event_c;
    res.slot_status       = mode_nxt;
    res.smoothed_distance = filt_nxt;
    res.occupied_total    = occ_nxt;
    res.error_total       = flt_nxt;
    res.available_total   = sorq_pkg::TOTAL_W'(sorq_pkg::NUM_SLOTS) - occ_nxt - flt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sorq_pkg::NUM_SLOTS; i++) begin
        mode_r[i]   <= sorq_pkg::MODE_FREE;
        saved_r[i]  <= 1'b0;
        pend_r[i]   <= 1'b0;
        tally_r[i]  <= '0;
        filt_r[i]   <= '0;
        primed_r[i] <= 1'b0;
      end
      occ_r <= '0;
      flt_r <= '0;
    end else if (step_en) begin
      mode_r[s]   <= mode_nxt;
      saved_r[s]  <= saved_nxt;
      pend_r[s]   <= pend_nxt;
      tally_r[s]  <= tally_nxt;
      filt_r[s]   <= filt_nxt;
      primed_r[s] <= primed_nxt;
      occ_r       <= occ_nxt;
      flt_r       <= flt_nxt;
    end
  end

endmodule

@@ src/slot_occupancy_qualifier.sv @@
// flow: an accepted reading is held in the input register and moves into the result
//   register when the result stage can advance; out_valid rises as that register is loaded
// throughput: one reading per cycle, sustained while out_ready is high; each slot's state
//   is read and written back in the same cycle as the result register is loaded
// reset (rst_n, synchronous): all slots free, filters unprimed, totals zero,
//   registers at their defaults, both pipeline stages empty
module slot_occupancy_qualifier (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sorq_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sorq_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sorq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sorq_pkg::DIST_W-1:0]     cfg_data
);

  sorq_pkg::cfg_t      cfg_r;
  sorq_pkg::in_item_t  in_r;
  logic                in_vld_r;
  sorq_pkg::out_item_t out_r;
  logic                out_vld_r;
  sorq_pkg::out_item_t res;
  logic                advance;
  logic                step_en;

  assign cfg_ready = 1'b1;
  assign advance   = !out_vld_r || out_ready;
  assign step_en   = in_vld_r && advance;
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_valid_distance    <= 13'd32;
      cfg_r.max_valid_distance    <= 13'd6400;
      cfg_r.occupied_threshold    <= 13'd800;
      cfg_r.free_threshold        <= 13'd1600;
      cfg_r.filter_weight         <= 9'd77;
      cfg_r.occupy_confirmations  <= 4'd3;
      cfg_r.release_confirmations <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sorq_pkg::REG_MIN_DIST:    cfg_r.min_valid_distance    <= cfg_data;
        sorq_pkg::REG_MAX_DIST:    cfg_r.max_valid_distance    <= cfg_data;
        sorq_pkg::REG_OCC_THRESH:  cfg_r.occupied_threshold    <= cfg_data;
        sorq_pkg::REG_FREE_THRESH: cfg_r.free_threshold        <= cfg_data;
        sorq_pkg::REG_WEIGHT:      cfg_r.filter_weight         <= cfg_data[sorq_pkg::WGT_W-1:0];
        sorq_pkg::REG_OCC_CONF:    cfg_r.occupy_confirmations  <= cfg_data[sorq_pkg::CONF_W-1:0];
        sorq_pkg::REG_REL_CONF:    cfg_r.release_confirmations <= cfg_data[sorq_pkg::CONF_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (step_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  sorq_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_r <= res;
    end
  end

  a_totals_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.occupied_total + out_r.error_total + out_r.available_total
                   == sorq_pkg::TOTAL_W'(sorq_pkg::NUM_SLOTS)))
    else $error("slot totals do not add up");

  a_event_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.slot_event == sorq_pkg::EVENT_OCCUPIED)
      |-> out_r.slot_status == sorq_pkg::MODE_OCCUPIED)
    else $error("occupied event without occupied status");

  a_free_event_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.slot_event == sorq_pkg::EVENT_FREED)
      |-> out_r.slot_status == sorq_pkg::MODE_FREE)
    else $error("free event without free status");

  a_step_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_vld_r)
    else $error("transfer into result stage lost");

endmodule
